// File: design/krt_pkg.sv
// Shared types, constants and command codes for the keyed record table.
package krt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int REC_W    = 96;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_LIST   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_in;     // capture the input transfer
        logic             clr_idx;     // scan index to zero
        logic             inc_idx;     // scan index plus one
        logic             rd_en;       // read the record at the scan index
        logic             rd_next;     // read at scan index plus one
        logic             wr_en;       // write a record
        logic [1:0]       wr_sel;      // 0 append, 1 update at idx, 2 shift to idx
        logic             cnt_inc;
        logic             cnt_dec;
        logic             save_hit;    // keep the record just read
        logic             out_load;    // load the result register
        logic [2:0]       out_status;
        logic [1:0]       out_src;     // 0 zeros, 1 read data, 2 input, 3 saved
        logic             out_last;
    } krt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0]       command;
        logic             key_match;   // read data key equals input key
        logic             bad_value;   // negative amount or price
        logic             cnt_zero;
        logic             cnt_full;
        logic             idx_at_end;  // scan index equals fill count
        logic             idx_at_last; // scan index plus one equals fill count
    } krt_stat_t;

endpackage

// File: design/krt_ram.sv
// Generic RAM with one write port and one read port; the read is registered.
module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: design/krt_datapath.sv
// Datapath: input registers, record memory, scan index, fill count, result register.
module krt_datapath
    import krt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  krt_cmd_t          cmd,
    output krt_stat_t         stat,
    input  logic [2:0]        in_command,
    input  logic [31:0]       in_key,
    input  logic [31:0]       in_amount,
    input  logic [31:0]       in_price,
    output logic [2:0]        res_status,
    output logic [REC_W-1:0]  res_rec,
    output logic [CNT_W-1:0]  res_count,
    output logic              res_last
);
    logic [2:0]       command_reg;
    logic [31:0]      key_reg, amount_reg, price_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REC_W-1:0] hit_reg;
    logic [REC_W-1:0] rdata, wdata;
    logic [CNT_W-1:0] raddr_full, waddr_full, idx_plus;
    logic [REC_W-1:0] out_rec;

    assign idx_plus = idx_reg + CNT_W'(1);

    always_comb begin
        idx_next = idx_reg;
        if (cmd.clr_idx) begin
            idx_next = '0;
        end else if (cmd.inc_idx) begin
            idx_next = idx_plus;
        end
        cnt_next = cnt_reg;
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            command_reg <= in_command;
            key_reg     <= in_key;
            amount_reg  <= in_amount;
            price_reg   <= in_price;
        end
        if (cmd.save_hit) begin
            hit_reg <= rdata;
        end
    end

    assign raddr_full = cmd.rd_next ? idx_plus : idx_reg;

    always_comb begin
        unique case (cmd.wr_sel)
            2'd0: begin
                waddr_full = cnt_reg;
                wdata      = {price_reg, amount_reg, key_reg};
            end
            2'd1: begin
                waddr_full = idx_reg;
                wdata      = {price_reg, amount_reg, rdata[31:0]};
            end
            default: begin
                waddr_full = idx_reg;
                wdata      = rdata;
            end
        endcase
    end

    krt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr_full[IDX_W-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr_full[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        unique case (cmd.out_src)
            2'd0:    out_rec = '0;
            2'd1:    out_rec = rdata;
            2'd2:    out_rec = {price_reg, amount_reg, key_reg};
            default: out_rec = hit_reg;
        endcase
    end

    // The count reported is the one after the command takes effect.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_status <= cmd.out_status;
            res_rec    <= out_rec;
            res_count  <= cnt_next;
            res_last   <= cmd.out_last;
        end
    end

    assign stat.command     = command_reg;
    assign stat.key_match   = (rdata[31:0] == key_reg);
    assign stat.bad_value   = amount_reg[31] | price_reg[31];
    assign stat.cnt_zero    = (cnt_reg == '0);
    assign stat.cnt_full    = (cnt_reg >= CNT_W'(CAPACITY));
    assign stat.idx_at_end  = (idx_reg == cnt_reg);
    assign stat.idx_at_last = (idx_plus == cnt_reg);
endmodule

// File: design/krt_ctrl.sv
// Controller state machine sequencing search, list, delete shift and result delivery.
module krt_ctrl
    import krt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output krt_cmd_t  cmd,
    input  krt_stat_t stat
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_RD     = 9'b000000100,
        S_CHK    = 9'b000001000,
        S_LREAD  = 9'b000010000,
        S_LOUT   = 9'b000100000,
        S_SHRD   = 9'b001000000,
        S_SHWR   = 9'b010000000,
        S_WAIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   mval_reg, mval_next;

    assign s_tready = (state_reg == S_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;

    always_comb begin
        state_next = state_reg;
        mval_next  = mval_reg && !m_tready;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load_in = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.out_last = 1'b1;
                if (stat.command > 3'(CMD_LIST)) begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = ST_INVALID;
                end else if (stat.command == 3'(CMD_INSERT) && stat.cnt_full) begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = ST_FULL;
                end else if (stat.command != 3'(CMD_INSERT) && stat.cnt_zero) begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = ST_EMPTY;
                end else if (stat.command == 3'(CMD_LIST)) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_LREAD;
                end else if (stat.idx_at_end) begin
                    state_next = S_CHK;  // insert into an empty table
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CHK;
                end
                if (cmd.out_load) begin
                    mval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                // Read data holds the record at the scan index unless the index is at the end.
                cmd.out_last = 1'b1;
                if (stat.idx_at_end) begin
                    cmd.out_load = 1'b1;
                    if (stat.command != 3'(CMD_INSERT)) begin
                        cmd.out_status = ST_NOT_FOUND;
                    end else if (stat.bad_value) begin
                        cmd.out_status = ST_INVALID;
                    end else begin
                        cmd.out_status = ST_OK;
                        cmd.out_src    = 2'd2;
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = 2'd0;
                        cmd.cnt_inc    = 1'b1;
                    end
                    mval_next  = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.key_match) begin
                    unique case (stat.command)
                        3'(CMD_INSERT): begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_DUPLICATE;
                            mval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        3'(CMD_UPDATE): begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_OK;
                            cmd.out_src    = 2'd2;
                            cmd.wr_en      = 1'b1;
                            cmd.wr_sel     = 2'd1;
                            mval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        3'(CMD_DELETE): begin
                            cmd.save_hit = 1'b1;
                            if (stat.idx_at_last) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_OK;
                                cmd.out_src    = 2'd1;
                                cmd.cnt_dec    = 1'b1;
                                mval_next  = 1'b1;
                                state_next = S_IDLE;
                            end else begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_next = 1'b1;
                                state_next  = S_SHWR;
                            end
                        end
                        default: begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_OK;
                            cmd.out_src    = 2'd1;
                            mval_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end else begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_SHRD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
                state_next  = S_SHWR;
            end
            S_SHWR: begin
                // Move the next record down into the slot at the scan index.
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = 2'd2;
                cmd.inc_idx = 1'b1;
                if (stat.idx_at_last) begin
                    // The slot at the old last index is spare now, so the delete is done.
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_src    = 2'd3;
                    cmd.out_last   = 1'b1;
                    cmd.cnt_dec    = 1'b1;
                    mval_next      = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    state_next = S_SHRD;
                end
            end
            S_LREAD: begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_OK;
                cmd.out_src    = 2'd1;
                cmd.out_last   = stat.idx_at_last;
                cmd.inc_idx    = 1'b1;
                mval_next      = 1'b1;
                state_next     = S_LOUT;
            end
            S_LOUT: begin
                if (!mval_reg || m_tready) begin
                    if (stat.idx_at_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                state_next = S_LREAD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end
endmodule

// File: design/keyed_record_table_top.sv
// Top level of the keyed record table: controller, datapath and stream ports.
// Commands are taken one at a time. Insert, lookup, update and delete search the
// table linearly from the oldest record, one record at a time, through the record
// memory, which has one write port and one registered read port; a delete then
// moves each later record down by one slot, and a list gives one result per
// record, waiting while a result is still pending on the output. The memory needs
// no clearing pass after reset.
module keyed_record_table_top
    import krt_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // command[2:0], key[34:3], amount[66:35], price_cents[98:67], zeros above
    input  logic [103:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // status[2:0], found_key[34:3], found_amount[66:35], found_price[98:67],
    // entry_count[105:99], zeros above
    output logic [111:0]  m_tdata,
    output logic          m_tlast
);
    krt_cmd_t         cmd;
    krt_stat_t        stat;
    logic [2:0]       res_status;
    logic [REC_W-1:0] res_rec;
    logic [CNT_W-1:0] res_count;

    krt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    krt_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_command (s_tdata[2:0]),
        .in_key     (s_tdata[34:3]),
        .in_amount  (s_tdata[66:35]),
        .in_price   (s_tdata[98:67]),
        .res_status (res_status),
        .res_rec    (res_rec),
        .res_count  (res_count),
        .res_last   (m_tlast)
    );

    assign m_tdata = {6'd0, res_count, res_rec, res_status};

`ifndef SYNTH
    a_no_take_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result is pending");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[105:99] <= 7'(CAPACITY))
        else $error("entry count above capacity");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != 3'(ST_OK)) |-> (m_tdata[98:3] == '0 && m_tlast))
        else $error("failed command reports a record");
`endif
endmodule
